/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational or same-cycle implication, checked at every clock edge out of reset
`define BTT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Antecedent in one cycle, consequent in the next
`define BTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hw/rtl/btt_pkg.sv */
// Types, codes and helpers for the bucketed transposition table
package btt_pkg;

	localparam int SET_BITS_DEF = 10;
	localparam int WAYS_DEF     = 4;
	localparam int QUEUE_DEPTH  = 2;
	localparam int KEY_W        = 64;
	localparam int WORTH_W      = 12;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	localparam logic [1:0] BOUND_EXACT = 2'd0;

	localparam logic [2:0] ST_LOOKUP  = 3'd0;
	localparam logic [2:0] ST_NEW     = 3'd1;
	localparam logic [2:0] ST_UPDATED = 3'd2;
	localparam logic [2:0] ST_KEPT    = 3'd3;
	localparam logic [2:0] ST_REJECT  = 3'd4;

	typedef struct packed {
		logic               operation;
		logic [KEY_W-1:0]   key;
		logic [7:0]         depth_in;
		logic [9:0]         move_number;
		logic [1:0]         bound_in;
		logic signed [15:0] eval_in;
		logic               book_in;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [7:0]         depth;
		logic [9:0]         move;
		logic [1:0]         bound;
		logic signed [15:0] eval;
		logic               book;
	} entry_t;

	typedef struct packed {
		logic               found;
		logic signed [15:0] eval_out;
		logic [7:0]         depth_out;
		logic [1:0]         bound_out;
		logic               book_out;
		logic [2:0]         status;
	} rsp_t;

	typedef enum logic [1:0] {
		ENG_CLEAR,
		ENG_IDLE,
		ENG_EXEC
	} eng_state_t;

	function automatic logic [WORTH_W-1:0] worth(input logic policy, input logic [7:0] depth,
			input logic [9:0] move, input logic [1:0] bound);
		logic [WORTH_W-1:0] v;
		if (policy) begin
			v = {2'b00, depth, 2'b00} + {{(WORTH_W-1){1'b0}}, (bound == BOUND_EXACT)};
		end else begin
			v = {4'b0000, depth} + {1'b0, move, 1'b0};
		end
		return v;
	endfunction

endpackage

/* hw/rtl/btt_ifs.sv */
// Request and response channel interfaces
interface btt_req_if;
	import btt_pkg::*;
	logic               valid;
	logic               ready;
	logic               operation;
	logic [KEY_W-1:0]   key;
	logic [7:0]         depth_in;
	logic [9:0]         move_number;
	logic [1:0]         bound_in;
	logic signed [15:0] eval_in;
	logic               book_in;
	modport source(output valid, operation, key, depth_in, move_number, bound_in, eval_in,
		book_in, input ready);
	modport sink(input valid, operation, key, depth_in, move_number, bound_in, eval_in,
		book_in, output ready);
endinterface

interface btt_rsp_if;
	logic               valid;
	logic               ready;
	logic               found;
	logic signed [15:0] eval_out;
	logic [7:0]         depth_out;
	logic [1:0]         bound_out;
	logic               book_out;
	logic [2:0]         status;
	modport source(output valid, found, eval_out, depth_out, bound_out, book_out, status,
		input ready);
	modport sink(input valid, found, eval_out, depth_out, bound_out, book_out, status,
		output ready);
endinterface

/* hw/rtl/bucketed_transposition_table_unit.sv */
// Top level of the bucketed transposition table
//
//  channel | dir | handshake     | content
//  req     | in  | valid/ready   | operation, key, insert fields
//  rsp     | out | valid/ready   | found, stored fields, status
//  cfg     | in  | cfg_we        | victim_policy in cfg_wdata
//
// In the back end each transaction does one set-memory read, then
// compare, victim choice, row write-back and response register load.
// After reset a clearing pass zeroes all 2^SET_BITS rows of the set memory;
// requests queue up (two deep) but are not served until it ends.
// A stalled response holds the back end; the queue keeps accepting until full.
module bucketed_transposition_table_unit #(
	parameter int SET_BITS = btt_pkg::SET_BITS_DEF,
	parameter int WAYS     = btt_pkg::WAYS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	btt_req_if.sink   req,
	btt_rsp_if.source rsp,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);
	import btt_pkg::*;

	head_t head;
	logic  pop;
	rsp_t  rsp_data;

	btt_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.head  (head),
		.pop   (pop)
	);

	btt_engine #(
		.SET_BITS(SET_BITS),
		.WAYS    (WAYS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.rsp_data (rsp_data),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready)
	);

	assign rsp.found     = rsp_data.found;
	assign rsp.eval_out  = rsp_data.eval_out;
	assign rsp.depth_out = rsp_data.depth_out;
	assign rsp.bound_out = rsp_data.bound_out;
	assign rsp.book_out  = rsp_data.book_out;
	assign rsp.status    = rsp_data.status;
endmodule

/* hw/rtl/btt_queue.sv */
// Front end: accepts request transactions into a short queue
module btt_queue (
	input  logic           clk,
	input  logic           arst_n,
	btt_req_if.sink        req,
	output btt_pkg::head_t head,
	input  logic           pop
);
	import btt_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             do_pop;
	item_t            in_item;

	assign req.ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign do_pop    = pop && (cnt_q != '0);

	always_comb begin
		in_item.operation   = req.operation;
		in_item.key         = req.key;
		in_item.depth_in    = req.depth_in;
		in_item.move_number = req.move_number;
		in_item.bound_in    = req.bound_in;
		in_item.eval_in     = req.eval_in;
		in_item.book_in     = req.book_in;
	end

	assign head.valid = (cnt_q != '0);
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(do_pop);
		end
	end
endmodule

/* hw/rtl/btt_engine.sv */
// Back end: set memory read-modify-write, victim choice and response register
module btt_engine #(
	parameter int SET_BITS = btt_pkg::SET_BITS_DEF,
	parameter int WAYS     = btt_pkg::WAYS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  btt_pkg::head_t head,
	output logic           pop,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	output btt_pkg::rsp_t  rsp_data,
	output logic           rsp_valid,
	input  logic           rsp_ready
);
	import btt_pkg::*;

	localparam int FILL_W = $clog2(WAYS + 1);
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ENT_W  = $bits(entry_t);
	localparam int ROW_W  = FILL_W + WAYS * ENT_W;
	localparam int NSETS  = 1 << SET_BITS;

	logic [ROW_W-1:0]    mem [NSETS];
	logic [ROW_W-1:0]    row_q;
	item_t               item_q;
	logic                policy_q;
	logic [SET_BITS-1:0] clr_q;
	eng_state_t          state_q, state_d;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic                out_free;
	logic                rd_en;
	logic                exec_go;
	logic                clr_we;
	logic                mem_we;
	logic [SET_BITS-1:0] wr_addr;
	logic [ROW_W-1:0]    wr_row;
	logic [ROW_W-1:0]    new_row;
	logic                row_write;
	rsp_t                res;

	entry_t              ways_w [WAYS];
	logic [FILL_W-1:0]   fill_w;

	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		fill_w = row_q[FILL_W-1:0];
		for (int i = 0; i < WAYS; i++) begin
			ways_w[i] = row_q[FILL_W + i*ENT_W +: ENT_W];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ENG_CLEAR: if (clr_q == '1) state_d = ENG_IDLE;
			ENG_IDLE:  if (head.valid) state_d = ENG_EXEC;
			ENG_EXEC:  if (out_free) state_d = ENG_IDLE;
			default:   state_d = ENG_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		rd_en   = 1'b0;
		exec_go = 1'b0;
		clr_we  = 1'b0;
		unique case (state_q)
			ENG_CLEAR: clr_we = 1'b1;
			ENG_IDLE:  rd_en = head.valid;
			ENG_EXEC:  exec_go = out_free;
			default: begin
			end
		endcase
	end

	assign pop = rd_en;

	always_comb begin
		entry_t             ent_new;
		logic               hit;
		logic [WAY_W-1:0]   first_idx;
		entry_t             old;
		logic               take;
		logic [WORTH_W-1:0] least;
		logic [WORTH_W-1:0] v;
		logic               have;
		logic [WAY_W-1:0]   pick;
		logic [WAY_W-1:0]   wsel;
		logic [FILL_W-1:0]  fill_n;

		ent_new.key   = item_q.key;
		ent_new.depth = item_q.depth_in;
		ent_new.move  = item_q.move_number;
		ent_new.bound = item_q.bound_in;
		ent_new.eval  = item_q.eval_in;
		ent_new.book  = item_q.book_in;

		res       = '0;
		hit       = 1'b0;
		first_idx = '0;
		row_write = 1'b0;
		wsel      = '0;
		fill_n    = fill_w;

		// lookup keeps the last match
		for (int i = 0; i < WAYS; i++) begin
			if ((FILL_W'(i) < fill_w) && (ways_w[i].key == item_q.key)) begin
				hit          = 1'b1;
				res.eval_out = ways_w[i].eval;
				res.depth_out = ways_w[i].depth;
				res.bound_out = ways_w[i].bound;
				res.book_out = ways_w[i].book;
			end
		end
		// insert acts on the first match
		for (int i = WAYS - 1; i >= 0; i--) begin
			if ((FILL_W'(i) < fill_w) && (ways_w[i].key == item_q.key)) begin
				first_idx = WAY_W'(i);
			end
		end
		old  = ways_w[first_idx];
		take = (item_q.depth_in > old.depth) ||
			((item_q.depth_in == old.depth) && (item_q.bound_in == BOUND_EXACT) &&
			(old.bound != BOUND_EXACT));

		least = worth(policy_q, item_q.depth_in, item_q.move_number, item_q.bound_in);
		have  = 1'b0;
		pick  = '0;
		for (int i = 0; i < WAYS; i++) begin
			v = worth(policy_q, ways_w[i].depth, ways_w[i].move, ways_w[i].bound);
			if (v < least) begin
				least = v;
				pick  = WAY_W'(i);
				have  = 1'b1;
			end
		end

		res.found = hit;
		if (item_q.operation == OP_LOOKUP) begin
			res.status = ST_LOOKUP;
		end else begin
			res.eval_out  = '0;
			res.depth_out = '0;
			res.bound_out = '0;
			res.book_out  = 1'b0;
			if (hit) begin
				wsel = first_idx;
				if (take) begin
					row_write  = 1'b1;
					res.status = ST_UPDATED;
				end else begin
					res.status = ST_KEPT;
				end
			end else if (fill_w < FILL_W'(WAYS)) begin
				wsel       = WAY_W'(fill_w);
				fill_n     = fill_w + 1'b1;
				row_write  = 1'b1;
				res.status = ST_NEW;
			end else if (have) begin
				wsel       = pick;
				row_write  = 1'b1;
				res.status = ST_NEW;
			end else begin
				res.status = ST_REJECT;
			end
		end

		new_row = row_q;
		new_row[FILL_W-1:0] = fill_n;
		for (int i = 0; i < WAYS; i++) begin
			if (WAY_W'(i) == wsel) begin
				new_row[FILL_W + i*ENT_W +: ENT_W] = ent_new;
			end
		end
	end

	assign mem_we  = clr_we || (exec_go && row_write);
	assign wr_addr = clr_we ? clr_q : item_q.key[SET_BITS-1:0];
	assign wr_row  = clr_we ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			row_q  <= mem[head.item.key[SET_BITS-1:0]];
			item_q <= head.item;
		end
		if (exec_go) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ENG_CLEAR;
			clr_q       <= '0;
			policy_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_we) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end
			if (exec_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_data  = rsp_q;
	assign rsp_valid = rsp_valid_q;
endmodule

/* hw/rtl/btt_checker.sv */
// Port-level checks for the transposition table top level
`include "assert_macros.svh"

module btt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               found,
	input logic signed [15:0] eval_out,
	input logic [7:0]         depth_out,
	input logic [1:0]         bound_out,
	input logic               book_out,
	input logic [2:0]         status
);
	import btt_pkg::*;

	`BTT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status))
	`BTT_ASSERT(a_status_range, clk, arst_n, !rsp_valid || status <= ST_REJECT)
	`BTT_ASSERT(a_insert_zero, clk, arst_n, !(rsp_valid && status != ST_LOOKUP) || (eval_out == 16'sd0 && depth_out == 8'd0 && bound_out == 2'd0 && !book_out))
	`BTT_ASSERT(a_miss_zero, clk, arst_n, !(rsp_valid && status == ST_LOOKUP && !found) || (eval_out == 16'sd0 && depth_out == 8'd0 && bound_out == 2'd0 && !book_out))
	`BTT_ASSERT(a_found_status, clk, arst_n, !rsp_valid || ((status == ST_UPDATED || status == ST_KEPT) == (found && status != ST_LOOKUP)))
endmodule

bind bucketed_transposition_table_unit btt_checker u_btt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.found    (rsp.found),
	.eval_out (rsp.eval_out),
	.depth_out(rsp.depth_out),
	.bound_out(rsp.bound_out),
	.book_out (rsp.book_out),
	.status   (rsp.status)
);
